### hw/rtl/aes256_pkg.sv
`timescale 1ns / 1ps
package aes256_pkg;

  localparam int NUM_ROUNDS  = 14;
  localparam int KEY_WORDS   = 8;
  localparam int SCHED_WORDS = 60;

  localparam logic [1:0] REG_KEY0 = 2'd0;
  localparam logic [1:0] REG_KEY1 = 2'd1;
  localparam logic [1:0] REG_KEY2 = 2'd2;
  localparam logic [1:0] REG_KEY3 = 2'd3;

  typedef struct packed {
    logic       load_blk;
    logic       do_round;
    logic       last_round;
    logic       key_init;
    logic       key_step;
    logic [5:0] key_idx;
    logic [5:0] rk_idx;
  } aes256_cmd_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] tbl [256];
    tbl = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tbl[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

### hw/rtl/aes256_ctrl.sv
`timescale 1ns / 1ps
module aes256_ctrl
  import aes256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        key_wr,
  input  logic        in_fire,
  input  logic        out_busy,
  output logic        in_ready,
  output logic        done,
  output aes256_cmd_t cmd
);

  typedef enum logic [1:0] {S_KEY, S_IDLE, S_ROUND} state_t;

  state_t     state_r, state_nxt;
  logic [5:0] kidx_r, kidx_nxt;
  logic [3:0] rnd_r, rnd_nxt;
  logic       kpend_r, kpend_nxt;
  logic       full_r, full_nxt;

  always_comb begin
    state_nxt = state_r;
    kidx_nxt  = kidx_r;
    rnd_nxt   = rnd_r;
    kpend_nxt = kpend_r | key_wr;
    cmd       = '0;
    in_ready  = 1'b0;
    // finished block moves to the output register once it has room
    done      = full_r && !out_busy;
    full_nxt  = full_r && out_busy;
    case (state_r)
      S_KEY: begin
        cmd.key_step = 1'b1;
        cmd.key_idx  = kidx_r;
        kidx_nxt     = kidx_r + 6'd1;
        if (kidx_r == 6'(SCHED_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = !kpend_r && !key_wr && (!full_r || !out_busy);
        if (kpend_r) begin
          cmd.key_init = 1'b1;
          kpend_nxt    = key_wr;
          kidx_nxt     = 6'(KEY_WORDS);
          state_nxt    = S_KEY;
        end else if (in_fire) begin
          cmd.load_blk = 1'b1;
          cmd.rk_idx   = 6'd0;
          rnd_nxt      = 4'd1;
          state_nxt    = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.do_round   = 1'b1;
        cmd.rk_idx     = {rnd_r, 2'b00};
        cmd.last_round = (rnd_r == 4'(NUM_ROUNDS));
        rnd_nxt        = rnd_r + 4'd1;
        if (rnd_r == 4'(NUM_ROUNDS)) begin
          full_nxt  = 1'b1;
          rnd_nxt   = 4'd0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kidx_r  <= '0;
      rnd_r   <= '0;
      kpend_r <= 1'b1;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kidx_r  <= kidx_nxt;
      rnd_r   <= rnd_nxt;
      kpend_r <= kpend_nxt;
      full_r  <= full_nxt;
    end
  end

endmodule

### hw/rtl/aes256_dp.sv
`timescale 1ns / 1ps
module aes256_dp
  import aes256_pkg::*;
(
  input  logic         clk,
  input  aes256_cmd_t  cmd,
  input  logic [255:0] key,
  input  logic [63:0]  blk_hi,
  input  logic [63:0]  blk_lo,
  input  logic [4:0]   nvalid,
  output logic [127:0] state_q
);

  // round key store, 4 words per row, one row read per cycle
  logic [127:0] rk_mem [15];
  logic [31:0]  win_r [8];
  logic [31:0]  row_r [3];
  logic [127:0] rk_q;
  logic [127:0] st_r;
  logic [31:0]  t, nw;
  logic [7:0]   rcon;
  logic [127:0] blk;
  logic [127:0] pt, sr, mc, ark_in;

  // sliding window of the last eight words
  always_comb begin
    t = win_r[7];
    case (cmd.key_idx[2:0])
      3'd0: begin
        case (cmd.key_idx[5:3])
          3'd1: rcon = 8'h01;
          3'd2: rcon = 8'h02;
          3'd3: rcon = 8'h04;
          3'd4: rcon = 8'h08;
          3'd5: rcon = 8'h10;
          3'd6: rcon = 8'h20;
          3'd7: rcon = 8'h40;
          default: rcon = 8'h00;
        endcase
        t = {sbox(win_r[7][23:16]) ^ rcon, sbox(win_r[7][15:8]),
             sbox(win_r[7][7:0]), sbox(win_r[7][31:24])};
      end
      3'd4: begin
        rcon = 8'h00;
        t = {sbox(win_r[7][31:24]), sbox(win_r[7][23:16]),
             sbox(win_r[7][15:8]), sbox(win_r[7][7:0])};
      end
      default: rcon = 8'h00;
    endcase
    nw = win_r[0] ^ t;
  end

  always_ff @(posedge clk) begin
    if (cmd.key_init) begin
      for (int i = 0; i < 8; i++) begin
        win_r[i] <= key[255 - 32*i -: 32];
      end
      rk_mem[0] <= key[255:128];
      rk_mem[1] <= key[127:0];
    end else if (cmd.key_step) begin
      for (int i = 0; i < 7; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[7] <= nw;
      case (cmd.key_idx[1:0])
        2'd0: row_r[0] <= nw;
        2'd1: row_r[1] <= nw;
        2'd2: row_r[2] <= nw;
        default: rk_mem[cmd.key_idx[5:2]] <= {row_r[0], row_r[1], row_r[2], nw};
      endcase
    end
  end

  // round key row is registered in the cycle before the round that uses it
  logic [3:0] rd_row;
  assign rd_row = cmd.load_blk ? 4'd1 : (cmd.last_round ? 4'd0 : cmd.rk_idx[5:2] + 4'd1);

  always_ff @(posedge clk) begin
    rk_q <= rk_mem[rd_row];
  end

  logic [127:0] rk0;
  assign rk0 = {win_r[0], win_r[1], win_r[2], win_r[3]};

  assign blk = {blk_hi, blk_lo};

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      pt[127 - 8*k -: 8] = (5'(k) < nvalid) ? blk[127 - 8*k -: 8] : 8'h00;
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127 - 8*(4*c+r) -: 8] = sbox(st_r[127 - 8*(4*((c+r)%4)+r) -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = sr[127 - 32*c -: 8];
      a1 = sr[119 - 32*c -: 8];
      a2 = sr[111 - 32*c -: 8];
      a3 = sr[103 - 32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      mc[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      mc[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      mc[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    ark_in = cmd.last_round ? sr : mc;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_blk) begin
      st_r <= pt ^ rk_mem[0];
    end else if (cmd.do_round) begin
      st_r <= ark_in ^ rk_q;
    end
  end

  assign state_q = st_r;

  logic unused;
  assign unused = ^rk0;

endmodule

### hw/rtl/aes256_block_encrypt.sv
`timescale 1ns / 1ps
// output: after the load and fourteen rounds the block waits until the output register has room, then out_tvalid rises
// input: load plus fourteen rounds on one round unit; no new item is taken until the last one is through
// between blocks, input also stalls while the output register is full and a finished block waits
// a key write starts a key expansion of words 8 to 59; no item is taken until it ends
// reset: synchronous active low, key registers cleared, key expanded from zero before the first item is accepted
module aes256_block_encrypt
  import aes256_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready,
  input  logic         in_tvalid,
  output logic         in_tready,
  // block_high, block_low, valid_bytes, zero fill
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // cipher_high, cipher_low
  output logic [127:0] out_tdata
);

  logic [63:0]  key_r [4];
  logic         wr, kwr, fire, done, ovalid_r;
  logic [127:0] st;
  logic [127:0] odata_r;
  aes256_cmd_t  cmd;

  assign cfg_pready = 1'b1;
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign kwr  = wr;
  assign fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else if (kwr) begin
      case (cfg_paddr[4:3])
        REG_KEY0: key_r[0] <= cfg_pwdata;
        REG_KEY1: key_r[1] <= cfg_pwdata;
        REG_KEY2: key_r[2] <= cfg_pwdata;
        REG_KEY3: key_r[3] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = key_r[cfg_paddr[4:3]];
  end

  aes256_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .key_wr   (kwr),
    .in_fire  (fire),
    .out_busy (ovalid_r && !out_tready),
    .in_ready (in_tready),
    .done     (done),
    .cmd      (cmd)
  );

  aes256_dp u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .key     ({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .blk_hi  (in_tdata[63:0]),
    .blk_lo  (in_tdata[127:64]),
    .nvalid  ((in_tdata[132:128] > 5'd16) ? 5'd16 : in_tdata[132:128]),
    .state_q (st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (done) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      odata_r <= {st[63:0], st[127:64]};
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  logic unused;
  assign unused = ^in_tdata[135:133];

endmodule
